/* design/ptpw_pkg.sv */
// Shared types and constants for the permuted tile page walker.
package ptpw_pkg;

   // Field widths
   localparam int GROUP_W    = 20;
   localparam int COUNT_W    = 21;
   localparam int ADDR_W     = 32;
   localparam int NT_W       = 11;
   localparam int CT_W       = 7;
   localparam int LR_W       = 16;
   localparam int WRAP_HI_W  = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int BLK_W      = 6;
   localparam int ROW_W      = 6;
   localparam int VALID_W    = 6;

   // Tile geometry
   localparam int ROWS_PER_TILE = 32;
   localparam int ROW_SHIFT     = $clog2(ROWS_PER_TILE);
   localparam int TILE_ROW_W    = GROUP_W + ROW_SHIFT;
   localparam int CT_MAX        = 64;
   localparam int GEOM_W        = NT_W + CT_W;

   // Defaults and sizing
   localparam int PTPW_STREAM_WIDTH = 1;
   localparam int QUEUE_DEPTH       = 2;

   // Register reset values
   localparam logic [NT_W-1:0]      TILES_PER_ROW_RST = NT_W'(1);
   localparam logic [CT_W-1:0]      CHANNEL_TILES_RST = CT_W'(1);
   localparam logic [LR_W-1:0]      LOGICAL_ROWS_RST  = LR_W'(32);
   localparam logic [GROUP_W-1:0]   GROUP_STEP_RST    = GROUP_W'(1);
   localparam logic [WRAP_HI_W-1:0] WRAP_HIGH_RST     = WRAP_HI_W'(1048576);
   localparam logic [GROUP_W-1:0]   WRAP_LOW_RST      = '0;

   typedef enum logic {
      OP_START = 1'b0,
      OP_NEXT  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILES_PER_ROW = 3'd0,
      CSR_CHANNEL_TILES = 3'd1,
      CSR_LOGICAL_ROWS  = 3'd2,
      CSR_GROUP_STEP    = 3'd3,
      CSR_WRAP_HIGH     = 3'd4,
      CSR_WRAP_LOW      = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_MUL1,
      BK_MUL2
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [GROUP_W-1:0]  start_group;
      logic [COUNT_W-1:0]  group_count;
      logic [ADDR_W-1:0]   source_base;
   } cmd_type;

   typedef struct packed {
      logic [NT_W-1:0]      tiles_per_row;
      logic [CT_W-1:0]      channel_tiles;
      logic [LR_W-1:0]      logical_rows;
      logic [GROUP_W-1:0]   grp_step;
      logic [WRAP_HI_W-1:0] wrap_high;
      logic [GROUP_W-1:0]   wrap_low;
   } cfg_type;

endpackage

/* design/ptpw_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
module ptpw_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [ptpw_pkg::GROUP_W-1:0] req_start_group,
   input  logic [ptpw_pkg::COUNT_W-1:0] req_group_count,
   input  logic [ptpw_pkg::ADDR_W-1:0]  req_source_base,
   input  logic                     q_pop,
   output logic                     q_valid,
   output ptpw_pkg::cmd_type        q_cmd
);
   import ptpw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   cmd_type            new_cmd;

   // Classify the incoming request
   always_comb begin
      new_cmd.op          = op_type'(req_op);
      new_cmd.start_group = req_start_group;
      new_cmd.group_count = req_group_count;
      new_cmd.source_base = req_source_base;
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !q_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (!push && q_pop) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* design/ptpw_div.sv */
// Restoring divider splitting a group index into row tile and column tile.
module ptpw_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptpw_pkg::GROUP_W-1:0]  dividend,
   input  logic [ptpw_pkg::NT_W-1:0]     divisor,
   output logic                          done,
   output logic [ptpw_pkg::GROUP_W-1:0]  quotient,
   output logic [ptpw_pkg::NT_W-1:0]     remainder
);
   import ptpw_pkg::*;

   localparam int CNT_W = $clog2(GROUP_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [GROUP_W-1:0]  quot_ff, quot_in;
   logic [NT_W-1:0]     rem_ff, rem_in;
   logic [NT_W-1:0]     dsr_ff, dsr_in;
   logic [NT_W:0]       rem_sh;
   logic [NT_W:0]       diff;
   logic                fits;

   // One quotient bit per cycle
   assign rem_sh = {rem_ff, quot_ff[GROUP_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};
   assign fits   = (rem_sh >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(GROUP_W - 1);
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[GROUP_W-2:0], fits};
         rem_in  = fits ? diff[NT_W-1:0] : rem_sh[NT_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = CNT_W'(cnt_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

/* design/ptpw_back.sv */
// Back end: walks groups, rows and stream pages and drives the response register.
module ptpw_back #(
   parameter int STREAM_WIDTH = ptpw_pkg::PTPW_STREAM_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ptpw_pkg::cfg_type            cfg,
   input  logic                         cfg_write,
   input  logic                         q_valid,
   input  ptpw_pkg::cmd_type            q_cmd,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ptpw_pkg::ADDR_W-1:0]  rsp_page_index,
   output logic [ptpw_pkg::ADDR_W-1:0]  rsp_base_address,
   output logic                         rsp_is_padding,
   output logic                         rsp_group_end,
   output logic                         rsp_walk_end,
   output logic                         rsp_exhausted
);
   import ptpw_pkg::*;

   localparam int SO_W = (STREAM_WIDTH > 1) ? $clog2(STREAM_WIDTH) : 1;
   localparam int RO_W = ROW_W + GEOM_W;

   // Walk state
   back_state_type      state_ff, state_in;
   logic [GROUP_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [SO_W-1:0]     so_ff, so_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic                stale_ff, stale_in;

   // Cached group geometry
   logic [ADDR_W-1:0]   p1_ff, p1_in;
   logic [GEOM_W-1:0]   rs_ff, rs_in;
   logic [GEOM_W-1:0]   pad_base_ff, pad_base_in;
   logic [VALID_W-1:0]  valid_ff, valid_in;
   logic [ADDR_W-1:0]   tile_ff, tile_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   page_ff, page_in;
   logic [ADDR_W-1:0]   base_out_ff, base_out_in;
   logic                pad_ff, pad_in;
   logic                gend_ff, gend_in;
   logic                wend_ff, wend_in;
   logic                exh_ff, exh_in;

   // Divider hookup
   logic                div_start;
   logic                div_done;
   logic [GROUP_W-1:0]  div_quot;
   logic [NT_W-1:0]     div_rem;

   // Datapath intermediates
   logic [NT_W-1:0]             nt_eff;
   logic [CT_W-1:0]             ct_eff;
   logic [TILE_ROW_W-1:0]       tile_row0;
   logic [TILE_ROW_W:0]         row_end;
   logic [TILE_ROW_W+NT_W-1:0]  p1_full;
   logic [ADDR_W+CT_W-1:0]      tile_full;
   logic [RO_W-1:0]             row_off;
   logic [ADDR_W-1:0]           ct0;
   logic [ADDR_W-1:0]           row_page;
   logic [ADDR_W-1:0]           fill_page;
   logic [ADDR_W-1:0]           page;
   logic                        pad;
   logic                        last_k;
   logic                        last_row;
   logic                        last_blk;
   logic                        gend;
   logic [COUNT_W-1:0]          grp_sum;
   logic [GROUP_W-1:0]          next_group;
   logic                        out_free;

   ptpw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cur_ff),
      .divisor   (nt_eff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Clamp configuration to usable ranges
   assign nt_eff = (cfg.tiles_per_row == '0) ? NT_W'(1) : cfg.tiles_per_row;
   assign ct_eff = (cfg.channel_tiles == '0)                 ? CT_W'(1) :
                   (cfg.channel_tiles > CT_W'(CT_MAX))       ? CT_W'(CT_MAX) :
                   cfg.channel_tiles;

   // Geometry products, one multiplier stage per state
   assign tile_row0 = {div_quot, {ROW_SHIFT{1'b0}}};
   assign row_end   = {1'b0, tile_row0} + (TILE_ROW_W+1)'(ROWS_PER_TILE);
   assign p1_full   = tile_row0 * nt_eff;
   assign tile_full = (p1_ff + ADDR_W'(div_rem)) * ct_eff;

   // Page address of the current step
   assign row_off   = row_ff * rs_ff;
   assign ct0       = ADDR_W'(blk_ff) * ADDR_W'(STREAM_WIDTH);
   assign row_page  = tile_ff + ADDR_W'(row_off) + ct0;
   assign fill_page = ADDR_W'(pad_base_ff) + ct0;
   assign pad       = (row_ff >= valid_ff);
   assign page      = (pad ? fill_page : row_page) + ADDR_W'(so_ff);

   // End-of-loop flags
   assign last_k   = (int'(so_ff) + 1 >= STREAM_WIDTH);
   assign last_row = (int'(row_ff) + 1 >= ROWS_PER_TILE);
   assign last_blk = ((int'(blk_ff) + 1) * STREAM_WIDTH >= int'(ct_eff));
   assign gend     = last_k && last_row && last_blk;

   // Group advance with fold
   assign grp_sum    = {1'b0, cur_ff} + {1'b0, cfg.grp_step};
   assign next_group = (grp_sum == cfg.wrap_high) ? cfg.wrap_low : grp_sum[GROUP_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state, walk update and response
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      blk_in       = blk_ff;
      row_in       = row_ff;
      so_in        = so_ff;
      base_in      = base_ff;
      stale_in     = stale_ff;
      p1_in        = p1_ff;
      rs_in        = rs_ff;
      pad_base_in  = pad_base_ff;
      valid_in     = valid_ff;
      tile_in      = tile_ff;
      rsp_valid_in = rsp_valid_ff;
      page_in      = page_ff;
      base_out_in  = base_out_ff;
      pad_in       = pad_ff;
      gend_in      = gend_ff;
      wend_in      = wend_ff;
      exh_in       = exh_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == OP_START) begin
                  q_pop    = 1'b1;
                  cur_in   = q_cmd.start_group;
                  left_in  = q_cmd.group_count;
                  base_in  = q_cmd.source_base;
                  blk_in   = '0;
                  row_in   = '0;
                  so_in    = '0;
                  stale_in = 1'b1;
               end else if (left_ff == '0) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     page_in      = '0;
                     base_out_in  = base_ff;
                     pad_in       = 1'b0;
                     gend_in      = 1'b0;
                     wend_in      = 1'b0;
                     exh_in       = 1'b1;
                  end
               end else if (stale_ff) begin
                  div_start = 1'b1;
                  state_in  = BK_DIVIDE;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  rsp_valid_in = 1'b1;
                  page_in      = page;
                  base_out_in  = base_ff;
                  pad_in       = pad;
                  gend_in      = gend;
                  wend_in      = gend && (left_ff == COUNT_W'(1));
                  exh_in       = 1'b0;
                  // Advance stream offset, row, channel block, group
                  if (!last_k) begin
                     so_in = SO_W'(so_ff + 1'b1);
                  end else begin
                     so_in = '0;
                     if (!last_row) begin
                        row_in = ROW_W'(row_ff + 1'b1);
                     end else begin
                        row_in = '0;
                        if (!last_blk) begin
                           blk_in = BLK_W'(blk_ff + 1'b1);
                        end else begin
                           blk_in   = '0;
                           left_in  = COUNT_W'(left_ff - 1'b1);
                           cur_in   = next_group;
                           stale_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         BK_DIVIDE: begin
            if (div_done) begin
               state_in = BK_MUL1;
            end
         end
         BK_MUL1: begin
            p1_in       = p1_full[ADDR_W-1:0];
            rs_in       = nt_eff * ct_eff;
            pad_base_in = div_rem * ct_eff;
            if (row_end <= (TILE_ROW_W+1)'(cfg.logical_rows)) begin
               valid_in = VALID_W'(ROWS_PER_TILE);
            end else if (tile_row0 >= TILE_ROW_W'(cfg.logical_rows)) begin
               valid_in = '0;
            end else begin
               valid_in = VALID_W'(TILE_ROW_W'(cfg.logical_rows) - tile_row0);
            end
            state_in = BK_MUL2;
         end
         BK_MUL2: begin
            tile_in  = tile_full[ADDR_W-1:0];
            stale_in = 1'b0;
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Any register write invalidates the cached geometry
      if (cfg_write) begin
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cur_ff       <= '0;
         left_ff      <= '0;
         blk_ff       <= '0;
         row_ff       <= '0;
         so_ff        <= '0;
         base_ff      <= '0;
         stale_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         blk_ff       <= blk_in;
         row_ff       <= row_in;
         so_ff        <= so_in;
         base_ff      <= base_in;
         stale_ff     <= stale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff       <= p1_in;
      rs_ff       <= rs_in;
      pad_base_ff <= pad_base_in;
      valid_ff    <= valid_in;
      tile_ff     <= tile_in;
      page_ff     <= page_in;
      base_out_ff <= base_out_in;
      pad_ff      <= pad_in;
      gend_ff     <= gend_in;
      wend_ff     <= wend_in;
      exh_ff      <= exh_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_index   = page_ff;
   assign rsp_base_address = base_out_ff;
   assign rsp_is_padding   = pad_ff;
   assign rsp_group_end    = gend_ff;
   assign rsp_walk_end     = wend_ff;
   assign rsp_exhausted    = exh_ff;

endmodule

/* design/permuted_tile_page_walker_unit.sv */
// Top level of the permuted tile page walker: register file, front end and back end.
//
// Usage: a request with op START latches start_group, group_count and source_base
// and produces no response. Each request with op NEXT produces exactly one response:
// the next source page of the walk, with padding, group-end and walk-end flags, or
// a response with exhausted set once all groups are done.
// Channels: req_* and rsp_* use valid/stall; a request is taken when valid is high
// and stall is low. csr_* writes one register per valid/ready beat; csr_ready is
// always high. Write registers only while the block is idle.
// A NEXT request that opens a new group waits for the group split: the back end
// starts the restoring divider, waits in BK_DIVIDE until it is done, forms the
// products in BK_MUL1 and BK_MUL2, and issues the page on its return to BK_IDLE.
// Within a group pages leave at one per cycle unless stalled. The divider sets the
// per-group cost, spread over channel blocks times 32 rows times the stream width.
// A two-entry request queue sits between the front and back ends, and the response
// register lets the back end compute the next page while a result is still waiting.
// Reset: synchronous, active high; clears the walk (no groups left) and loads the
// register defaults. A stalled response holds; the back end stops once the
// response register is full and the queue fills and raises req_stall.
module permuted_tile_page_walker_unit #(
   parameter int STREAM_WIDTH = ptpw_pkg::PTPW_STREAM_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [ptpw_pkg::GROUP_W-1:0]    req_start_group,
   input  logic [ptpw_pkg::COUNT_W-1:0]    req_group_count,
   input  logic [ptpw_pkg::ADDR_W-1:0]     req_source_base,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ptpw_pkg::ADDR_W-1:0]     rsp_page_index,
   output logic [ptpw_pkg::ADDR_W-1:0]     rsp_base_address,
   output logic                            rsp_is_padding,
   output logic                            rsp_group_end,
   output logic                            rsp_walk_end,
   output logic                            rsp_exhausted,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ptpw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptpw_pkg::CSR_DATA_W-1:0] csr_data
);
   import ptpw_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_write;
   logic     q_valid;
   logic     q_pop;
   cmd_type  q_cmd;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (csr_index)
            CSR_TILES_PER_ROW: cfg_in.tiles_per_row = csr_data[NT_W-1:0];
            CSR_CHANNEL_TILES: cfg_in.channel_tiles = csr_data[CT_W-1:0];
            CSR_LOGICAL_ROWS:  cfg_in.logical_rows  = csr_data[LR_W-1:0];
            CSR_GROUP_STEP:    cfg_in.grp_step      = csr_data[GROUP_W-1:0];
            CSR_WRAP_HIGH:     cfg_in.wrap_high     = csr_data[WRAP_HI_W-1:0];
            CSR_WRAP_LOW:      cfg_in.wrap_low      = csr_data[GROUP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tiles_per_row <= TILES_PER_ROW_RST;
         cfg_ff.channel_tiles <= CHANNEL_TILES_RST;
         cfg_ff.logical_rows  <= LOGICAL_ROWS_RST;
         cfg_ff.grp_step      <= GROUP_STEP_RST;
         cfg_ff.wrap_high     <= WRAP_HIGH_RST;
         cfg_ff.wrap_low      <= WRAP_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptpw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_start_group (req_start_group),
      .req_group_count (req_group_count),
      .req_source_base (req_source_base),
      .q_pop           (q_pop),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd)
   );

   ptpw_back #(
      .STREAM_WIDTH (STREAM_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cfg_write        (cfg_write),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_page_index   (rsp_page_index),
      .rsp_base_address (rsp_base_address),
      .rsp_is_padding   (rsp_is_padding),
      .rsp_group_end    (rsp_group_end),
      .rsp_walk_end     (rsp_walk_end),
      .rsp_exhausted    (rsp_exhausted)
   );

endmodule
